// ----- hw/rtl/tna_pkg.sv -----
// Package: widths, constants and helper types for the triangle normal/area block.
`default_nettype none
package tna_pkg;
    localparam int VTX_W   = 21;
    localparam int EDGE_W  = 22;
    localparam int CROSS_W = 45;   // signed cross component
    localparam int MAG_W   = 44;   // cross magnitude
    localparam int SQ_W    = 90;   // sum of squares
    localparam int LEN_W   = 45;   // square root result (L < 2^45)
    localparam int NORM_W  = 16;
    localparam int NORM_FRAC = 14;
    localparam int AREA_W  = 24;
    localparam int TOTAL_W = 40;
    localparam int AREA_SHIFT = 21;
    localparam int QUO_W   = 15;   // quotient bits 0..16384
    localparam logic [AREA_W-1:0]  AREA_MAX  = {AREA_W{1'b1}};
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
    localparam int IN_W  = 9 * VTX_W;          // 189 bits
    localparam int IN_TW = 192;
    localparam int OUT_W = 3 * NORM_W + AREA_W + TOTAL_W;   // 112
    localparam int OUT_TW = 112;
    localparam int MUL_STEPS = 22;             // serial multiply over edge width
    localparam int SQRT_STEPS = 45;
    localparam int DIV_STEPS = 16;

    typedef struct packed {
        logic start;
        logic busy;
    } tna_ctl_t;
endpackage
`default_nettype wire

// ----- hw/rtl/triangle_normal_area.sv -----
// Top level: triangle face normal, face area and running mesh area.
// One triangle at a time: an accepted request runs six bit-serial products
// on one shared multiplier, three bit-serial squares of the cross
// magnitudes, a square root on the sum of squares and three divisions
// before a valid result; a zero-length face skips the divisions. The next
// request is taken only once the result is in the output register. A result
// waits in the output register while the next request is taken and computed.
// A zero-length cross product gives a zero normal and zero area.
`default_nettype none
module triangle_normal_area
    import tna_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z (21 bits each), zero pad
    input  wire logic [IN_TW-1:0]  s_axis_tdata,
    input  wire logic              s_axis_tlast,   // last_face
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    // normal_x, normal_y, normal_z (16 each), face_area (24), mesh_area (40)
    output logic [OUT_TW-1:0]      m_axis_tdata,
    output logic                   m_axis_tlast    // mesh_done
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_SQRT = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] step_reg;       // product index / division index
    logic       pend_reg;       // a unit was started and not yet done
    logic signed [EDGE_W-1:0] e1x_reg, e1y_reg, e1z_reg, e2x_reg, e2y_reg, e2z_reg;
    logic signed [CROSS_W-1:0] cx_reg, cy_reg, cz_reg;
    logic       last_reg;
    logic [LEN_W-1:0] len_reg;
    logic [NORM_W-1:0] nx_reg, ny_reg, nz_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic       out_valid_reg;
    logic [OUT_TW-1:0] out_data_reg;
    logic       out_last_reg;

    logic signed [VTX_W-1:0] ax, ay, az, bx, by, bz, qx, qy, qz;
    logic accept, out_fire;
    tna_ctl_t mul_ctl, sqrt_ctl, div_ctl;
    logic signed [EDGE_W-1:0] mul_a, mul_b;
    logic mul_done, sqrt_done, div_done;
    logic signed [2*EDGE_W-1:0] mul_p;
    logic [LEN_W-1:0] root;
    logic [QUO_W-1:0] quo;
    logic signed [CROSS_W-1:0] div_c;
    logic [MAG_W-1:0] div_m;
    logic [MAG_W-1:0] mx, my, mz;
    logic [SQ_W-1:0] sumsq;
    logic [LEN_W-AREA_SHIFT-1:0] area_raw;
    logic [AREA_W-1:0] area;
    logic [TOTAL_W:0] tot_sum;
    logic [TOTAL_W-1:0] tot;
    logic [NORM_W-1:0] nval;

    assign ax = s_axis_tdata[0*VTX_W +: VTX_W];
    assign ay = s_axis_tdata[1*VTX_W +: VTX_W];
    assign az = s_axis_tdata[2*VTX_W +: VTX_W];
    assign bx = s_axis_tdata[3*VTX_W +: VTX_W];
    assign by = s_axis_tdata[4*VTX_W +: VTX_W];
    assign bz = s_axis_tdata[5*VTX_W +: VTX_W];
    assign qx = s_axis_tdata[6*VTX_W +: VTX_W];
    assign qy = s_axis_tdata[7*VTX_W +: VTX_W];
    assign qz = s_axis_tdata[8*VTX_W +: VTX_W];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;

    // product order: e1y*e2z, e1z*e2y, e1z*e2x, e1x*e2z, e1x*e2y, e1y*e2x
    always_comb
    begin
        case (step_reg)
            3'd0: begin mul_a = e1y_reg; mul_b = e2z_reg; end
            3'd1: begin mul_a = e1z_reg; mul_b = e2y_reg; end
            3'd2: begin mul_a = e1z_reg; mul_b = e2x_reg; end
            3'd3: begin mul_a = e1x_reg; mul_b = e2z_reg; end
            3'd4: begin mul_a = e1x_reg; mul_b = e2y_reg; end
            3'd5: begin mul_a = e1y_reg; mul_b = e2x_reg; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign mul_ctl.start  = (state_reg == ST_MUL) && !pend_reg;
    assign mul_ctl.busy   = pend_reg;
    assign sqrt_ctl.start = (state_reg == ST_SQRT) && !pend_reg;
    assign sqrt_ctl.busy  = pend_reg;
    assign div_ctl.start  = (state_reg == ST_DIV) && !pend_reg && (len_reg != '0);
    assign div_ctl.busy   = pend_reg;

    tna_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_ctl.start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .p     (mul_p)
    );

    assign mx = MAG_W'(cx_reg[CROSS_W-1] ? -cx_reg : cx_reg);
    assign my = MAG_W'(cy_reg[CROSS_W-1] ? -cy_reg : cy_reg);
    assign mz = MAG_W'(cz_reg[CROSS_W-1] ? -cz_reg : cz_reg);
    // the three squares are summed bit-serially, one multiplier bit per cycle
    logic [SQ_W-1:0] sq_acc_reg;
    logic [1:0]      sq_idx_reg;
    logic [MAG_W-1:0] sq_op;
    logic            sq_run_reg;
    logic [5:0]      sq_cnt_reg;
    logic [SQ_W-1:0] sq_mcand_reg;
    logic [MAG_W-1:0] sq_mplier_reg;

    assign sumsq = sq_acc_reg;

    tna_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_ctl.start && (sq_idx_reg == 2'd3)),
        .radicand (sumsq),
        .done     (sqrt_done),
        .root     (root)
    );

    always_comb
    begin
        case (step_reg)
            3'd0: div_c = cx_reg;
            3'd1: div_c = cy_reg;
            default: div_c = cz_reg;
        endcase
    end
    assign div_m = MAG_W'(div_c[CROSS_W-1] ? -div_c : div_c);

    // quotient of m/len with 15 fraction bits, rounded half up to 14
    tna_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_ctl.start),
        .num   (div_m),
        .den   (len_reg),
        .done  (div_done),
        .quo   (quo)
    );

    assign nval = div_c[CROSS_W-1] ? -NORM_W'(quo) : NORM_W'(quo);

    always_comb
    begin
        case (sq_idx_reg)
            2'd0: sq_op = mx;
            2'd1: sq_op = my;
            default: sq_op = mz;
        endcase
    end

    assign area_raw = len_reg[LEN_W-1:AREA_SHIFT];
    assign area     = AREA_W'(area_raw);
    assign tot_sum  = {1'b0, total_reg} + (TOTAL_W+1)'(area);
    assign tot      = tot_sum[TOTAL_W] ? TOTAL_MAX : tot_sum[TOTAL_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            pend_reg      <= 1'b0;
            sq_idx_reg    <= '0;
            sq_run_reg    <= 1'b0;
            sq_cnt_reg    <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_fire)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_MUL;
                        step_reg  <= '0;
                        pend_reg  <= 1'b0;
                    end
                end
                ST_MUL:
                begin
                    if (!pend_reg)
                        pend_reg <= 1'b1;
                    else if (mul_done)
                    begin
                        pend_reg <= 1'b0;
                        if (step_reg == 3'd5)
                        begin
                            state_reg  <= ST_SQRT;
                            sq_idx_reg <= '0;
                        end
                        else
                            step_reg <= step_reg + 3'd1;
                    end
                end
                ST_SQRT:
                begin
                    if (sq_idx_reg != 2'd3)
                    begin
                        if (!sq_run_reg)
                        begin
                            sq_run_reg <= 1'b1;
                            sq_cnt_reg <= '0;
                        end
                        else
                        begin
                            sq_cnt_reg <= sq_cnt_reg + 6'd1;
                            if (sq_cnt_reg == 6'(MAG_W - 1))
                            begin
                                sq_run_reg <= 1'b0;
                                sq_idx_reg <= sq_idx_reg + 2'd1;
                            end
                        end
                    end
                    else if (!pend_reg)
                        pend_reg <= 1'b1;
                    else if (sqrt_done)
                    begin
                        pend_reg  <= 1'b0;
                        state_reg <= ST_DIV;
                        step_reg  <= '0;
                    end
                end
                ST_DIV:
                begin
                    if (len_reg == '0)
                        state_reg <= ST_OUT;
                    else if (!pend_reg)
                        pend_reg <= 1'b1;
                    else if (div_done)
                    begin
                        pend_reg <= 1'b0;
                        if (step_reg == 3'd2)
                            state_reg <= ST_OUT;
                        else
                            step_reg <= step_reg + 3'd1;
                    end
                end
                ST_OUT:
                begin
                    if (!out_valid_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        total_reg     <= last_reg ? '0 : tot;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            e1x_reg  <= EDGE_W'(bx) - EDGE_W'(ax);
            e1y_reg  <= EDGE_W'(by) - EDGE_W'(ay);
            e1z_reg  <= EDGE_W'(bz) - EDGE_W'(az);
            e2x_reg  <= EDGE_W'(qx) - EDGE_W'(ax);
            e2y_reg  <= EDGE_W'(qy) - EDGE_W'(ay);
            e2z_reg  <= EDGE_W'(qz) - EDGE_W'(az);
            last_reg <= s_axis_tlast;
        end
        if (state_reg == ST_MUL && pend_reg && mul_done)
        begin
            case (step_reg)
                3'd0: cx_reg <= CROSS_W'(mul_p);
                3'd1: cx_reg <= cx_reg - CROSS_W'(mul_p);
                3'd2: cy_reg <= CROSS_W'(mul_p);
                3'd3: cy_reg <= cy_reg - CROSS_W'(mul_p);
                3'd4: cz_reg <= CROSS_W'(mul_p);
                3'd5: cz_reg <= cz_reg - CROSS_W'(mul_p);
                default: cx_reg <= cx_reg;
            endcase
        end
        if (state_reg == ST_MUL)
        begin
            sq_acc_reg <= '0;
        end
        else if (state_reg == ST_SQRT && sq_idx_reg != 2'd3)
        begin
            if (!sq_run_reg)
            begin
                sq_mcand_reg  <= SQ_W'(sq_op);
                sq_mplier_reg <= sq_op;
            end
            else
            begin
                if (sq_mplier_reg[0])
                    sq_acc_reg <= sq_acc_reg + sq_mcand_reg;
                sq_mcand_reg  <= sq_mcand_reg << 1;
                sq_mplier_reg <= sq_mplier_reg >> 1;
            end
        end
        if (state_reg == ST_SQRT && pend_reg && sqrt_done)
            len_reg <= root;
        if (state_reg == ST_DIV && len_reg == '0)
        begin
            nx_reg <= '0;
            ny_reg <= '0;
            nz_reg <= '0;
        end
        else if (state_reg == ST_DIV && pend_reg && div_done)
        begin
            case (step_reg)
                3'd0: nx_reg <= nval;
                3'd1: ny_reg <= nval;
                default: nz_reg <= nval;
            endcase
        end
        if (state_reg == ST_OUT && !out_valid_reg)
        begin
            out_data_reg <= {tot, area, nz_reg, ny_reg, nx_reg};
            out_last_reg <= last_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;
endmodule
`default_nettype wire

// ----- hw/rtl/tna_mul.sv -----
// Bit-serial signed multiplier: EDGE_W x EDGE_W product, one multiplier bit per cycle.
`default_nettype none
module tna_mul
    import tna_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic signed [EDGE_W-1:0]  a,
    input  wire logic signed [EDGE_W-1:0]  b,
    output logic                           done,
    output logic signed [2*EDGE_W-1:0]     p
);
    logic [4:0] cnt_reg, cnt_next;
    logic       run_reg, run_next;
    logic signed [2*EDGE_W-1:0] acc_reg, acc_next;
    logic signed [2*EDGE_W-1:0] mcand_reg, mcand_next;
    logic [EDGE_W-1:0] mplier_reg, mplier_next;
    logic last_bit;

    assign last_bit = (cnt_reg == 5'(EDGE_W - 1));

    always_comb
    begin
        run_next    = run_reg;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        if (start)
        begin
            run_next    = 1'b1;
            cnt_next    = '0;
            acc_next    = '0;
            mcand_next  = (2*EDGE_W)'(a);
            mplier_next = b;
        end
        else if (run_reg)
        begin
            // top multiplier bit has negative weight
            if (mplier_reg[0])
                acc_next = last_bit ? acc_reg - mcand_reg : acc_reg + mcand_reg;
            mcand_next  = mcand_reg <<< 1;
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg + 5'd1;
            if (last_bit)
                run_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
            done    <= 1'b0;
        end
        else
        begin
            run_reg <= run_next;
            cnt_reg <= cnt_next;
            done    <= run_reg && last_bit;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign p = acc_reg;
endmodule
`default_nettype wire

// ----- hw/rtl/tna_sqrt.sv -----
// Restoring square root, one result bit per cycle.
`default_nettype none
module tna_sqrt
    import tna_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [SQ_W-1:0]   radicand,
    output logic                   done,
    output logic [LEN_W-1:0]       root
);
    logic             run_reg;
    logic [5:0]       cnt_reg;
    logic [SQ_W-1:0]  rad_reg;
    logic [LEN_W+1:0] rem_reg;
    logic [LEN_W-1:0] root_reg;
    logic [LEN_W+1:0] rem_sh;
    logic [LEN_W+1:0] trial;
    logic             fits;

    assign rem_sh = {rem_reg[LEN_W-1:0], rad_reg[SQ_W-1 -: 2]};
    assign trial  = {root_reg, 2'b01};
    assign fits   = rem_sh >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
            done    <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(SQRT_STEPS - 1))
                begin
                    run_reg <= 1'b0;
                    done    <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (run_reg)
        begin
            rad_reg  <= rad_reg << 2;
            rem_reg  <= fits ? rem_sh - trial : rem_sh;
            root_reg <= {root_reg[LEN_W-2:0], fits};
        end
    end

    assign root = root_reg;
endmodule
`default_nettype wire

// ----- hw/rtl/tna_div.sv -----
// Restoring divider: round(m * 2^14 / len), one quotient bit per cycle.
`default_nettype none
module tna_div
    import tna_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [MAG_W-1:0]  num,
    input  wire logic [LEN_W-1:0]  den,
    output logic                   done,
    output logic [QUO_W-1:0]       quo
);
    // q_reg = floor(m * 2^15 / len); the rounded result is (q_reg + 1) >> 1
    logic             run_reg;
    logic [4:0]       cnt_reg;
    logic [LEN_W+1:0] rem_reg;
    logic [LEN_W+1:0] dvs_reg;
    logic [DIV_STEPS-1:0] q_reg;
    logic [LEN_W+1:0] rem_sh;
    logic             ge;

    // remainder and divisor are both kept doubled, so the first step
    // compares m against len without losing a bit
    assign rem_sh = {rem_reg[LEN_W:0], 1'b0};
    assign ge     = rem_sh >= dvs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
            done    <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(DIV_STEPS - 1))
                begin
                    run_reg <= 1'b0;
                    done    <= 1'b1;
                end
            end
        end
    end

    // m <= len, so the first step yields the integer bit, then 15 fraction bits
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= (LEN_W+2)'(num);
            dvs_reg <= {1'b0, den, 1'b0};
            q_reg   <= '0;
        end
        else if (run_reg)
        begin
            rem_reg <= ge ? rem_sh - dvs_reg : rem_sh;
            q_reg   <= {q_reg[DIV_STEPS-2:0], ge};
        end
    end

    assign quo = QUO_W'((17'(q_reg) + 17'd1) >> 1);
endmodule
`default_nettype wire

// ----- hw/rtl/tna_checker.sv -----
// Port-level checker for the triangle normal/area block, with its bind.
`default_nettype none
module tna_checker
    import tna_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              s_axis_tvalid,
    input wire logic              s_axis_tready,
    input wire logic              m_axis_tvalid,
    input wire logic              m_axis_tready,
    input wire logic [OUT_TW-1:0] m_axis_tdata,
    input wire logic              m_axis_tlast
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped while stalled");
    a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second request taken while busy");
    a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[15:0]) <= 16384)
            && ($signed(m_axis_tdata[15:0]) >= -16384))
        else $error("normal out of range");
    a_area_le_total: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> 40'(m_axis_tdata[71:48]) <= m_axis_tdata[111:72])
        else $error("mesh area below face area");
    a_last_known: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !$isunknown(m_axis_tlast))
        else $error("mesh_done unknown on a valid result");
endmodule

bind triangle_normal_area tna_checker u_tna_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

// ----- dv/tb_triangle_normal_area.sv -----
// Testbench for triangle_normal_area: random and directed triangles checked against a predictor.
`default_nettype none
module tb_triangle_normal_area;
    import tna_pkg::*;

    typedef struct {
        logic [IN_TW-1:0] data;
        logic             last;
    } tri_req_t;

    typedef struct {
        logic [NORM_W-1:0]  nx, ny, nz;
        logic [AREA_W-1:0]  area;
        logic [TOTAL_W-1:0] total;
        logic               done;
    } face_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_TW-1:0] s_axis_tdata = '0;
    logic s_axis_tlast = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_TW-1:0] m_axis_tdata;
    logic m_axis_tlast;

    tri_req_t  pending_tris[$];
    face_res_t expected_faces[$];
    logic [TOTAL_W-1:0] mesh_sum = '0;
    int  errors = 0;
    int  idle_cycles = 0;
    int  send_idle_pct = 12;
    int  recv_idle_pct = 50;
    int  hold_off = 0;
    bit  stim_done = 0;
    bit  pause_send = 0;

    always #5 clk = ~clk;

    triangle_normal_area dut (.*);

    function automatic logic signed [VTX_W-1:0] vtx(logic [IN_TW-1:0] d, int i);
        return d[i*VTX_W +: VTX_W];
    endfunction

    function automatic logic [LEN_W-1:0] floor_sqrt(logic [SQ_W-1:0] s);
        logic [LEN_W-1:0] r;
        logic [LEN_W-1:0] t;
        r = '0;
        for (int b = 43; b >= 0; b--)
        begin
            t = r | (45'd1 << b);
            if ({45'd0, t} * {45'd0, t} <= s)
                r = t;
        end
        return r;
    endfunction

    function automatic logic [NORM_W-1:0] unit_part(logic signed [CROSS_W-1:0] c,
                                                    logic [LEN_W-1:0] len);
        logic [63:0] m;
        logic [63:0] q;
        if (len == 0)
            return '0;
        m = c < 0 ? 64'(-c) : 64'(c);
        q = ((m << NORM_FRAC) + (len >> 1)) / len;
        if (q > 64'd16384)
            q = 64'd16384;
        if (c < 0)
            q = -q;
        return q[NORM_W-1:0];
    endfunction

    // Computes the face result and advances the running mesh total.
    function automatic face_res_t face_of(tri_req_t t);
        face_res_t r;
        logic signed [EDGE_W-1:0] e1[3], e2[3];
        logic signed [CROSS_W-1:0] cx, cy, cz;
        logic [SQ_W-1:0] s;
        logic [LEN_W-1:0] len;
        logic [LEN_W-1:0] a;
        logic [TOTAL_W:0] sum;
        for (int i = 0; i < 3; i++)
        begin
            e1[i] = EDGE_W'(vtx(t.data, 3 + i)) - EDGE_W'(vtx(t.data, i));
            e2[i] = EDGE_W'(vtx(t.data, 6 + i)) - EDGE_W'(vtx(t.data, i));
        end
        cx = CROSS_W'(e1[1]) * e2[2] - CROSS_W'(e1[2]) * e2[1];
        cy = CROSS_W'(e1[2]) * e2[0] - CROSS_W'(e1[0]) * e2[2];
        cz = CROSS_W'(e1[0]) * e2[1] - CROSS_W'(e1[1]) * e2[0];
        s = SQ_W'(cx) * SQ_W'(cx) + SQ_W'(cy) * SQ_W'(cy) + SQ_W'(cz) * SQ_W'(cz);
        len = floor_sqrt(s);
        r.nx = unit_part(cx, len);
        r.ny = unit_part(cy, len);
        r.nz = unit_part(cz, len);
        a = len >> AREA_SHIFT;
        r.area = a > LEN_W'(AREA_MAX) ? AREA_MAX : a[AREA_W-1:0];
        sum = {1'b0, mesh_sum} + r.area;
        r.total = sum > {1'b0, TOTAL_MAX} ? TOTAL_MAX : sum[TOTAL_W-1:0];
        r.done = t.last;
        mesh_sum = t.last ? '0 : r.total;
        return r;
    endfunction

    function automatic logic [VTX_W-1:0] rand_vtx(int mode);
        case (mode)
            0: return VTX_W'($urandom);
            1: return VTX_W'($urandom_range(0, 255) - 128);
            2: return 21'h0FFFFF;
            default: return 21'h100000;
        endcase
    endfunction

    task automatic push_tri(logic [VTX_W-1:0] v[9], logic last);
        tri_req_t t;
        t.data = '0;
        for (int i = 0; i < 9; i++)
            t.data[i*VTX_W +: VTX_W] = v[i];
        t.last = last;
        pending_tris.push_back(t);
    endtask

    // Driver
    always @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            expected_faces.push_back(face_of('{s_axis_tdata, s_axis_tlast}));
        if ((!s_axis_tvalid || s_axis_tready) )
        begin
            if (pending_tris.size() > 0 && !pause_send && $urandom_range(0, 99) >= send_idle_pct)
            begin
                tri_req_t t;
                t = pending_tris.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= t.data;
                s_axis_tlast <= t.last;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Monitor
    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (expected_faces.size() == 0)
            begin
                $error("unexpected result");
                errors++;
            end
            else
            begin
                face_res_t e;
                e = expected_faces.pop_front();
                if (m_axis_tdata[15:0] !== e.nx)
                begin
                    $error("normal_x exp %0h got %0h", e.nx, m_axis_tdata[15:0]);
                    errors++;
                end
                if (m_axis_tdata[31:16] !== e.ny)
                begin
                    $error("normal_y exp %0h got %0h", e.ny, m_axis_tdata[31:16]);
                    errors++;
                end
                if (m_axis_tdata[47:32] !== e.nz)
                begin
                    $error("normal_z exp %0h got %0h", e.nz, m_axis_tdata[47:32]);
                    errors++;
                end
                if (m_axis_tdata[71:48] !== e.area)
                begin
                    $error("face_area exp %0h got %0h", e.area, m_axis_tdata[71:48]);
                    errors++;
                end
                if (m_axis_tdata[111:72] !== e.total)
                begin
                    $error("mesh_area exp %0h got %0h", e.total, m_axis_tdata[111:72]);
                    errors++;
                end
                if (m_axis_tlast !== e.done)
                begin
                    $error("mesh_done exp %0b got %0b", e.done, m_axis_tlast);
                    errors++;
                end
            end
        end
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= $urandom_range(0, 99) >= recv_idle_pct;
    end

    // Watchdog
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        logic [VTX_W-1:0] v[9];
        int mode;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        // directed: all-zero (degenerate), extremes, axis-aligned, collinear
        v = '{default: '0};
        push_tri(v, 1'b0);
        v = '{default: 21'h0FFFFF};
        push_tri(v, 1'b0);
        v = '{21'h100000, 21'h100000, 21'h100000, 21'h0FFFFF, 21'h100000, 21'h100000,
              21'h100000, 21'h0FFFFF, 21'h0FFFFF};
        push_tri(v, 1'b0);
        v = '{21'h0FFFFF, 21'h0FFFFF, 21'h0FFFFF, 21'h100000, 21'h0FFFFF, 21'h100000,
              21'h0FFFFF, 21'h100000, 21'h100000};
        push_tri(v, 1'b0);
        v = '{0, 0, 0, 4096, 0, 0, 0, 4096, 0};
        push_tri(v, 1'b1);
        v = '{0, 0, 0, 4096, 4096, 4096, 8192, 8192, 8192};
        push_tri(v, 1'b0);
        v = '{0, 0, 0, 0, 0, 1, 0, 1, 0};
        push_tri(v, 1'b1);
        // large faces accumulated into one mesh total, well short of saturation
        for (int i = 0; i < 18; i++)
        begin
            v = '{21'h100000, 21'h100000, 0, 21'h0FFFFF, 21'h100000, 0,
                  21'h100000, 21'h0FFFFF, 21'h0FFFFF};
            push_tri(v, i == 17);
        end
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = ph == 0 ? 12 : (ph == 1 ? 50 : 0);
            recv_idle_pct = ph == 0 ? 50 : (ph == 1 ? 12 : 0);
            if (ph == 1)
                hold_off = 3000;
            for (int i = 0; i < 670; i++)
            begin
                mode = $urandom_range(0, 9);
                for (int k = 0; k < 9; k++)
                    v[k] = rand_vtx(mode < 6 ? 0 : (mode < 9 ? 1 : $urandom_range(0, 3)));
                if (mode == 8)
                    v[6:8] = v[3:5];
                push_tri(v, $urandom_range(0, 15) == 0);
            end
            wait (pending_tris.size() == 0 && !s_axis_tvalid);
            pause_send = 1;
            wait (expected_faces.size() == 0);
            repeat (300) @(posedge clk);
            pause_send = 0;
        end
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
`default_nettype wire
